// ===== hw/rtl/rrqq_pkg.sv =====
// Package with item types, status codes and sequencer states of the round-robin quantum queue.
package rrqq_pkg;

  // Fixed field widths of the item interfaces.
  localparam int unsigned ReqTypeW  = 1;
  localparam int unsigned BurstW    = 16;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned ServedW   = 16;
  localparam int unsigned JobCountW = 7;
  localparam int unsigned RemSumW   = 22;
  localparam int unsigned AvgW      = 24;
  localparam int unsigned QuantumW  = 16;
  localparam int unsigned FracBits  = 8;

  // Request kinds.
  localparam logic [ReqTypeW-1:0] ReqAdd      = 1'b0;
  localparam logic [ReqTypeW-1:0] ReqDispatch = 1'b1;

  typedef enum logic [StatusW-1:0] {
    ST_ADDED    = 3'd0,
    ST_IGNORED  = 3'd1,
    ST_REQUEUED = 3'd2,
    ST_FINISHED = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [ReqTypeW-1:0] req_type;
    logic [BurstW-1:0]   burst_time;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [ServedW-1:0]   served_time;
    logic [JobCountW-1:0] job_count;
    logic [RemSumW-1:0]   remaining_sum;
    logic [AvgW-1:0]      average_q8;
  } rsp_t;

endpackage

// ===== hw/rtl/round_robin_quantum_queue.sv =====
// Top level of the round-robin quantum queue: job memory, sequencer and serial divider.
//
// Each item runs through these steps from start to the result strobe: the oldest
// job is read from the job memory, the queue is updated, the restoring divider
// forms the Q8 average one quotient bit per cycle over a dividend of DIVD_W =
// TIME_BITS + clog2(QUEUE_DEPTH + 1) + 8 bits, and the result is shown. busy is
// high from the cycle after start until the end of the result cycle; the next item
// may start in the cycle after that. The result is shown for exactly one cycle with
// result_valid_o and must be captured then, as the block cannot be held off. The
// quantum register may be written at any time the block is not busy.
module round_robin_quantum_queue
  import rrqq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned TIME_BITS   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  req_t                req_i,
  output logic                result_valid_o,
  output rsp_t                rsp_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [QuantumW-1:0] cfg_data_i
);

  localparam int unsigned PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W   = TIME_BITS + CNT_W;
  localparam int unsigned CMP_W   = (TIME_BITS > BurstW) ? TIME_BITS : BurstW;
  localparam int unsigned DIVD_W  = SUM_W + FracBits;
  localparam int unsigned STEP_W  = $clog2(DIVD_W + 1);

  state_e state_q, state_d;

  logic [QuantumW-1:0]  quantum_q;
  logic [PTR_W-1:0]     oldest_q, oldest_d;
  logic [PTR_W-1:0]     newest_q, newest_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [SUM_W-1:0]     sum_q, sum_d;

  req_t                 req_q;
  status_e              status_q, status_d;
  logic [ServedW-1:0]   served_q, served_d;

  logic [DIVD_W-1:0]    divd_q, divd_d;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [AvgW-1:0]      quo_q, quo_d;
  logic [STEP_W-1:0]    step_q, step_d;

  logic                 accept;
  logic                 mem_re;
  logic                 mem_we;
  logic [TIME_BITS-1:0] mem_wdata;
  logic [TIME_BITS-1:0] rd_data_q;
  logic [TIME_BITS-1:0] job_store [QUEUE_DEPTH];

  logic [CMP_W-1:0]     burst_ext;
  logic [TIME_BITS-1:0] burst_m;
  logic [CMP_W-1:0]     quant_ext;
  logic [CMP_W-1:0]     rem_ext;
  logic [CMP_W-1:0]     left_ext;
  logic [CNT_W:0]       trial;
  logic                 qbit;

  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // Next state of the item sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_EXEC;
      S_EXEC: state_d = S_DIV;
      S_DIV:  if (step_q == STEP_W'(1)) state_d = S_OUT;
      S_OUT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Handshake outputs and memory read enable.
  always_comb begin
    busy           = 1'b1;
    result_valid_o = 1'b0;
    mem_re         = 1'b0;
    case (state_q)
      S_IDLE: begin
        busy   = 1'b0;
        mem_re = accept;
      end
      S_OUT: result_valid_o = 1'b1;
      default: begin
        busy           = 1'b1;
        result_valid_o = 1'b0;
      end
    endcase
  end

  // Queue update: decides the item from the oldest job read in the previous cycle.
  always_comb begin
    burst_ext = CMP_W'(req_q.burst_time);
    burst_m   = TIME_BITS'(burst_ext);
    quant_ext = (quantum_q == '0) ? CMP_W'(1) : CMP_W'(quantum_q);
    rem_ext   = CMP_W'(rd_data_q);
    left_ext  = rem_ext - quant_ext;

    oldest_d  = oldest_q;
    newest_d  = newest_q;
    count_d   = count_q;
    sum_d     = sum_q;
    status_d  = status_q;
    served_d  = served_q;
    mem_we    = 1'b0;
    mem_wdata = burst_m;

    if (state_q == S_EXEC) begin
      served_d = '0;
      if (req_q.req_type == ReqAdd) begin
        if (burst_m == '0) begin
          status_d = ST_IGNORED;
        end else if (count_q == CNT_W'(QUEUE_DEPTH)) begin
          status_d = ST_FULL;
        end else begin
          mem_we   = 1'b1;
          newest_d = (newest_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : newest_q + PTR_W'(1);
          count_d  = count_q + CNT_W'(1);
          sum_d    = sum_q + SUM_W'(burst_m);
          status_d = ST_ADDED;
        end
      end else if (count_q == '0) begin
        status_d = ST_EMPTY;
      end else begin
        oldest_d = (oldest_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : oldest_q + PTR_W'(1);
        if (rem_ext > quant_ext) begin
          // Charge one quantum and put the rest back as the newest job.
          mem_we    = 1'b1;
          mem_wdata = TIME_BITS'(left_ext);
          newest_d  = (newest_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : newest_q + PTR_W'(1);
          sum_d     = sum_q - SUM_W'(quant_ext);
          served_d  = ServedW'(quant_ext);
          status_d  = ST_REQUEUED;
        end else begin
          count_d   = count_q - CNT_W'(1);
          sum_d     = sum_q - SUM_W'(rd_data_q);
          served_d  = ServedW'(rem_ext);
          status_d  = ST_FINISHED;
        end
      end
    end
  end

  // Restoring divider: one quotient bit of (sum << 8) / count per cycle.
  always_comb begin
    trial  = {rem_q, divd_q[DIVD_W-1]};
    qbit   = (trial >= {1'b0, count_q});
    divd_d = divd_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    step_d = step_q;
    if (state_q == S_EXEC) begin
      divd_d = {sum_d, FracBits'(0)};
      rem_d  = '0;
      quo_d  = '0;
      step_d = STEP_W'(DIVD_W);
    end else if (state_q == S_DIV) begin
      divd_d = divd_q << 1;
      rem_d  = qbit ? CNT_W'(trial - {1'b0, count_q}) : trial[CNT_W-1:0];
      quo_d  = {quo_q[AvgW-2:0], qbit};
      step_d = step_q - STEP_W'(1);
    end
  end

  // Control state and queue bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      quantum_q <= QuantumW'(1);
      oldest_q  <= '0;
      newest_q  <= '0;
      count_q   <= '0;
      sum_q     <= '0;
      step_q    <= '0;
    end else begin
      state_q  <= state_d;
      oldest_q <= oldest_d;
      newest_q <= newest_d;
      count_q  <= count_d;
      sum_q    <= sum_d;
      step_q   <= step_d;
      if (cfg_valid_i && cfg_ready_o) begin
        quantum_q <= cfg_data_i;
      end
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    status_q <= status_d;
    served_q <= served_d;
    divd_q   <= divd_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
  end

  // Job memory: one write port at the newest slot, registered read of the oldest slot.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      job_store[newest_q] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= job_store[oldest_q];
    end
  end

  // Result fields.
  always_comb begin
    rsp_o.status        = status_q;
    rsp_o.served_time   = served_q;
    rsp_o.job_count     = JobCountW'(count_q);
    rsp_o.remaining_sum = RemSumW'(sum_q);
    rsp_o.average_q8    = (count_q == '0) ? '0 : quo_q;
  end

  // The result strobe lasts one cycle and only appears while busy.
  a_strobe_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy ##1 !result_valid_o)
    else $error("result strobe longer than one cycle or outside a busy period");

  // An empty queue holds no remaining time and has matching pointers.
  a_empty_consistent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (sum_q == '0) && (oldest_q == newest_q))
    else $error("empty queue with remaining time or misaligned pointers");

  // The job count never passes the queue depth, and a full queue wraps its pointers together.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CNT_W'(QUEUE_DEPTH)) &&
    ((count_q != CNT_W'(QUEUE_DEPTH)) || (oldest_q == newest_q)))
    else $error("job count beyond queue depth or pointers inconsistent");

  // The result strobe only follows the divider state.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == S_DIV))
    else $error("result strobe not preceded by the divider");

endmodule

// ===== sim/round_robin_quantum_queue_checker.sv =====
// Checker for the round-robin quantum queue: predicts every result and compares it with the block.
module round_robin_quantum_queue_checker
  import rrqq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                busy,
  input  req_t                req_i,
  input  logic                result_valid_o,
  input  rsp_t                rsp_o,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_o,
  input  logic [QuantumW-1:0] cfg_data_i,
  output int unsigned         mismatch_count_o,
  output int unsigned         awaited_count_o
);

  // Shadow copy of the job queue and of the quantum register.
  logic [BurstW-1:0]    job_times [QUEUE_DEPTH];
  int unsigned          oldest_slot;
  int unsigned          newest_slot;
  logic [JobCountW-1:0] jobs_queued;
  logic [RemSumW-1:0]   work_left;
  logic [QuantumW-1:0]  slice_len;

  // Results predicted but not yet seen, oldest first.
  rsp_t awaited_rsp [$];

  function automatic int unsigned next_slot(input int unsigned slot);
    return (slot == QUEUE_DEPTH - 1) ? 0 : slot + 1;
  endfunction

  // Applies one item to the shadow queue and returns the result it should give.
  task automatic schedule_item(input req_t item, output rsp_t outcome);
    logic [QuantumW-1:0] charge;
    logic [BurstW-1:0]   left;
    logic [RemSumW+FracBits-1:0] scaled;
    outcome = '0;
    if (item.req_type == ReqAdd) begin
      // A zero burst is ignored even when the queue is full.
      if (item.burst_time == '0) begin
        outcome.status = ST_IGNORED;
      end else if (jobs_queued == JobCountW'(QUEUE_DEPTH)) begin
        outcome.status = ST_FULL;
      end else begin
        job_times[newest_slot] = item.burst_time;
        newest_slot = next_slot(newest_slot);
        jobs_queued = jobs_queued + 1'b1;
        work_left = work_left + RemSumW'(item.burst_time);
        outcome.status = ST_ADDED;
      end
    end else if (jobs_queued == '0) begin
      outcome.status = ST_EMPTY;
    end else begin
      // A quantum of zero behaves as a quantum of one.
      charge = (slice_len == '0) ? QuantumW'(1) : slice_len;
      left = job_times[oldest_slot];
      oldest_slot = next_slot(oldest_slot);
      if (left > charge) begin
        outcome.served_time = charge;
        job_times[newest_slot] = left - charge;
        newest_slot = next_slot(newest_slot);
        work_left = work_left - RemSumW'(charge);
        outcome.status = ST_REQUEUED;
      end else begin
        outcome.served_time = left;
        jobs_queued = jobs_queued - 1'b1;
        work_left = work_left - RemSumW'(left);
        outcome.status = ST_FINISHED;
      end
    end
    outcome.job_count = jobs_queued;
    outcome.remaining_sum = work_left;
    if (jobs_queued != '0) begin
      scaled = {work_left, FracBits'(0)};
      outcome.average_q8 = AvgW'(scaled / jobs_queued);
    end
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count_o = mismatch_count_o + 1;
    end
  endtask

  // Compare results, track quantum writes and predict each accepted item.
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    rsp_t fresh;
    if (!rst_ni) begin
      oldest_slot = 0;
      newest_slot = 0;
      jobs_queued = '0;
      work_left = '0;
      slice_len = QuantumW'(1);
      awaited_rsp.delete();
      mismatch_count_o = 0;
      awaited_count_o = 0;
    end else begin
      if (result_valid_o) begin
        if (awaited_rsp.size() == 0) begin
          $error("result with status %0d arrived with no item outstanding",
                 rsp_o.status);
          mismatch_count_o = mismatch_count_o + 1;
        end else begin
          want = awaited_rsp.pop_front();
          check_field("status", want.status, rsp_o.status);
          check_field("served_time", want.served_time, rsp_o.served_time);
          check_field("job_count", want.job_count, rsp_o.job_count);
          check_field("remaining_sum", want.remaining_sum, rsp_o.remaining_sum);
          check_field("average_q8", want.average_q8, rsp_o.average_q8);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        slice_len = cfg_data_i;
      end
      if (start && !busy) begin
        schedule_item(req_i, fresh);
        awaited_rsp.push_back(fresh);
      end
      awaited_count_o = awaited_rsp.size();
    end
  end

endmodule

// ===== sim/round_robin_quantum_queue_test.sv =====
// Testbench top for the round-robin quantum queue: clock, reset, stimulus and verdict.
module round_robin_quantum_queue_test
  import rrqq_pkg::*;
();

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 40;
  localparam int unsigned Depth      = 64;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  req_t                req_i;
  logic                result_valid_o;
  rsp_t                rsp_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [QuantumW-1:0] cfg_data_i;
  int unsigned         mismatch_count;
  int unsigned         awaited_count;
  int unsigned         cycle_count = 0;
  bit                  gaps_on;

  round_robin_quantum_queue dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  round_robin_quantum_queue_checker #(
    .QUEUE_DEPTH (Depth)
  ) checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .req_i            (req_i),
    .result_valid_o   (result_valid_o),
    .rsp_o            (rsp_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .awaited_count_o  (awaited_count)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Issues one item, sometimes after a random gap, and returns at the edge that takes it.
  task automatic issue_item(input logic [ReqTypeW-1:0] kind, input logic [BurstW-1:0] burst);
    req_t item;
    item.req_type = kind;
    item.burst_time = burst;
    if (gaps_on && $urandom_range(0, 99) < 34) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= item;
    do @(posedge clk_i); while (busy);
  endtask

  // Holds off until every outstanding item has returned its result.
  task automatic settle;
    start <= 1'b0;
    do @(posedge clk_i); while (awaited_count != 0 || busy);
  endtask

  // Writes the quantum register while the block is idle.
  task automatic write_quantum(input logic [QuantumW-1:0] value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Burst times: mostly short jobs, with zeros and the whole range mixed in.
  function automatic logic [BurstW-1:0] pick_burst();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return '0;
    if (roll < 55) return BurstW'($urandom_range(1, 64));
    if (roll < 78) return BurstW'($urandom_range(65, 2000));
    return BurstW'($urandom_range(0, 65535));
  endfunction

  // Random phase: add share in percent; ignored adds do not count towards the total.
  task automatic run_phase(input int unsigned add_pct, input int unsigned total);
    int unsigned counted;
    logic [BurstW-1:0] burst;
    counted = 0;
    while (counted < total) begin
      if ($urandom_range(0, 99) < add_pct) begin
        burst = pick_burst();
        issue_item(ReqAdd, burst);
        if (burst != '0) counted++;
      end else begin
        issue_item(ReqDispatch, BurstW'($urandom_range(0, 65535)));
        counted++;
      end
    end
  endtask

  // Stimulus.
  initial begin
    rst_ni <= 1'b0;
    start <= 1'b0;
    req_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    gaps_on = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset quantum of one: empty, zero burst, field extremes.
    issue_item(ReqDispatch, 16'hFFFF);
    issue_item(ReqAdd, 16'h0000);
    issue_item(ReqAdd, 16'hFFFF);
    issue_item(ReqAdd, 16'h0001);
    issue_item(ReqAdd, 16'hAAAA);
    issue_item(ReqAdd, 16'h5555);
    issue_item(ReqDispatch, 16'h0000);
    issue_item(ReqDispatch, 16'h0000);
    issue_item(ReqDispatch, 16'h0000);
    // A zero quantum charges one unit.
    write_quantum(16'h0000);
    issue_item(ReqDispatch, 16'h0000);
    issue_item(ReqDispatch, 16'h0000);
    // The widest quantum finishes every job, including one exactly equal to it.
    write_quantum(16'hFFFF);
    issue_item(ReqAdd, 16'hFFFF);
    repeat (5) issue_item(ReqDispatch, 16'h0000);

    // Fill the empty queue, then add to it when full, with and without a zero burst.
    for (int unsigned n = 0; n < Depth; n++) begin
      issue_item(ReqAdd, BurstW'($urandom_range(1, 65535)));
    end
    issue_item(ReqAdd, 16'h0001);
    issue_item(ReqAdd, 16'h0000);
    repeat (Depth + 2) issue_item(ReqDispatch, 16'h0000);

    // Random phases across several quanta; each boundary waits for all results.
    write_quantum(16'h0001);
    run_phase(55, 90);
    write_quantum(16'h0000);
    run_phase(50, 60);
    write_quantum(16'hFFFF);
    run_phase(85, 90);
    // A long stretch without gaps that drains the queue.
    gaps_on = 1'b0;
    run_phase(15, 90);
    gaps_on = 1'b1;
    write_quantum(QuantumW'($urandom_range(1, 300)));
    run_phase(50, 90);
    write_quantum(QuantumW'($urandom_range(0, 65535)));
    run_phase(50, 90);

    // Wait for the last results, then a little longer for anything stray.
    settle();
    repeat (DrainWait) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
